// File: rtl/afrd_pkg.sv
// Shared types and constants for the API frame receive deframer.
`default_nettype none
package afrd_pkg;

    localparam logic [7:0] START_BYTE     = 8'h7E;
    localparam logic [7:0] TYPE_RECEIVE   = 8'h81;
    localparam logic [7:0] TYPE_TX_STATUS = 8'h89;
    localparam logic [7:0] SUM_BASE       = 8'hFF;
    localparam logic [15:0] PAYLOAD_OFFSET = 16'd4;
    localparam logic [15:0] TX_MIN_CONTENT = 16'd2;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        ST_RX_OK     = 3'd0,
        ST_TX_OK     = 3'd1,
        ST_ZERO_LEN  = 3'd2,
        ST_BAD_SUM   = 3'd3,
        ST_BAD_TYPE  = 3'd4,
        ST_TOO_SHORT = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        OP_SRC_HI,
        OP_SRC_LO,
        OP_RSSI,
        OP_OPTIONS,
        OP_FRAME_ID,
        OP_DELIVERY,
        OP_PAYLOAD,
        OP_END
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        status_t     status;
        logic [15:0] len;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } slot_t;

endpackage
`default_nettype wire

// File: rtl/afrd_ifs.sv
// Valid/ready channel interfaces for received bytes and deframer results.
`default_nettype none
interface afrd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afrd_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data;
    logic [15:0] src_addr;
    logic [7:0]  rssi;
    logic [7:0]  rx_options;
    logic [15:0] payload_len;
    logic [7:0]  frame_id;
    logic [7:0]  delivery_status;
    logic [2:0]  status;
    logic        last;

    modport source (output valid, output kind, output data, output src_addr, output rssi,
                    output rx_options, output payload_len, output frame_id,
                    output delivery_status, output status, output last, input ready);
    modport sink   (input valid, input kind, input data, input src_addr, input rssi,
                    input rx_options, input payload_len, input frame_id,
                    input delivery_status, input status, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/afrd_front.sv
// Frame parser: tracks frame phase and checksum, classifies received bytes into commands.
`default_nettype none
module afrd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    afrd_byte_if.sink          byte_ch,
    input  wire logic          queue_full,
    output afrd_pkg::slot_t    push
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_TYPE,
        PH_CONTENT,
        PH_CHECK
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] idx_reg, idx_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  type_reg, type_next;

    logic        take;
    logic [7:0]  b;
    logic [15:0] count;
    logic [15:0] need;
    logic [15:0] idx_inc;
    logic        is_rx;
    logic        is_tx;

    assign byte_ch.ready = !queue_full;
    assign take    = byte_ch.valid && !queue_full;
    assign b       = byte_ch.rx_byte;
    assign count   = len_reg - 16'd1;
    assign idx_inc = idx_reg + 16'd1;
    assign is_rx   = type_reg == afrd_pkg::TYPE_RECEIVE;
    assign is_tx   = type_reg == afrd_pkg::TYPE_TX_STATUS;
    assign need    = is_tx ? afrd_pkg::TX_MIN_CONTENT : afrd_pkg::PAYLOAD_OFFSET;

    always_comb
    begin
        phase_next      = phase_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        type_next       = type_reg;
        push.valid      = 1'b0;
        push.cmd.op     = afrd_pkg::OP_END;
        push.cmd.data   = b;
        push.cmd.status = afrd_pkg::ST_RX_OK;
        push.cmd.len    = count - afrd_pkg::PAYLOAD_OFFSET;
        if (take)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (b == afrd_pkg::START_BYTE)
                        phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_next   = {b, 8'h00};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next = {len_reg[15:8], b};
                    if ({len_reg[15:8], b} == 16'd0)
                    begin
                        push.valid      = 1'b1;
                        push.cmd.status = afrd_pkg::ST_ZERO_LEN;
                        phase_next      = PH_HUNT;
                    end
                    else
                        phase_next = PH_TYPE;
                end
                PH_TYPE:
                begin
                    type_next  = b;
                    sum_next   = b;
                    idx_next   = 16'd0;
                    phase_next = (len_reg == 16'd1) ? PH_CHECK : PH_CONTENT;
                end
                PH_CONTENT:
                begin
                    sum_next = sum_reg + b;
                    if (is_rx)
                    begin
                        push.valid = 1'b1;
                        case (idx_reg)
                            16'd0:   push.cmd.op = afrd_pkg::OP_SRC_HI;
                            16'd1:   push.cmd.op = afrd_pkg::OP_SRC_LO;
                            16'd2:   push.cmd.op = afrd_pkg::OP_RSSI;
                            16'd3:   push.cmd.op = afrd_pkg::OP_OPTIONS;
                            default: push.cmd.op = afrd_pkg::OP_PAYLOAD;
                        endcase
                    end
                    else if (is_tx)
                    begin
                        if (idx_reg == 16'd0)
                        begin
                            push.valid  = 1'b1;
                            push.cmd.op = afrd_pkg::OP_FRAME_ID;
                        end
                        else if (idx_reg == 16'd1)
                        begin
                            push.valid  = 1'b1;
                            push.cmd.op = afrd_pkg::OP_DELIVERY;
                        end
                    end
                    idx_next = idx_inc;
                    if (idx_inc == count)
                        phase_next = PH_CHECK;
                end
                PH_CHECK:
                begin
                    push.valid = 1'b1;
                    if (count < need)
                        push.cmd.status = afrd_pkg::ST_TOO_SHORT;
                    else if (!is_rx && !is_tx)
                        push.cmd.status = afrd_pkg::ST_BAD_TYPE;
                    else if ((afrd_pkg::SUM_BASE - sum_reg) != b)
                        push.cmd.status = afrd_pkg::ST_BAD_SUM;
                    else if (is_tx)
                        push.cmd.status = afrd_pkg::ST_TX_OK;
                    else
                        push.cmd.status = afrd_pkg::ST_RX_OK;
                    phase_next = PH_HUNT;
                end
                default:
                    phase_next = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            len_reg   <= 16'd0;
            idx_reg   <= 16'd0;
            sum_reg   <= 8'd0;
            type_reg  <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            type_reg  <= type_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/afrd_queue.sv
// Command queue between the parser and the result stage.
`default_nettype none
module afrd_queue #(
    parameter int DEPTH = afrd_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire afrd_pkg::slot_t push,
    output logic                 full,
    output afrd_pkg::slot_t      head,
    input  wire logic            pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    afrd_pkg::cmd_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push, do_pop;

    assign full       = cnt_reg == DEPTH_CNT;
    assign head.valid = cnt_reg != '0;
    assign head.cmd   = mem[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push.cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push.valid)
        else $error("command pushed into full queue");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_CNT)
        else $error("queue count above depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("queue count did not follow push");

endmodule
`default_nettype wire

// File: rtl/afrd_back.sv
// Result stage: executes queued commands, keeps header fields, drives the output register.
`default_nettype none
module afrd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire afrd_pkg::slot_t head,
    output logic                 pop,
    afrd_result_if.source        result_ch
);

    logic [15:0] src_reg;
    logic [7:0]  rssi_reg;
    logic [7:0]  opt_reg;
    logic [7:0]  fid_reg;
    logic [7:0]  dstat_reg;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [7:0]  out_data_reg;
    logic [15:0] out_src_reg;
    logic [7:0]  out_rssi_reg;
    logic [7:0]  out_opt_reg;
    logic [15:0] out_len_reg;
    logic [7:0]  out_fid_reg;
    logic [7:0]  out_dstat_reg;
    logic [2:0]  out_status_reg;

    logic is_emit;
    logic slot_free;
    logic load;

    assign is_emit   = head.cmd.op == afrd_pkg::OP_PAYLOAD || head.cmd.op == afrd_pkg::OP_END;
    assign slot_free = !out_valid_reg || result_ch.ready;
    assign pop       = head.valid && (!is_emit || slot_free);
    assign load      = head.valid && is_emit && slot_free;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            case (head.cmd.op)
                afrd_pkg::OP_SRC_HI:   src_reg[15:8] <= head.cmd.data;
                afrd_pkg::OP_SRC_LO:   src_reg[7:0]  <= head.cmd.data;
                afrd_pkg::OP_RSSI:     rssi_reg      <= head.cmd.data;
                afrd_pkg::OP_OPTIONS:  opt_reg       <= head.cmd.data;
                afrd_pkg::OP_FRAME_ID: fid_reg       <= head.cmd.data;
                afrd_pkg::OP_DELIVERY: dstat_reg     <= head.cmd.data;
                default: ;
            endcase
        end
        if (load)
        begin
            out_kind_reg   <= head.cmd.op == afrd_pkg::OP_END;
            out_data_reg   <= 8'd0;
            out_src_reg    <= 16'd0;
            out_rssi_reg   <= 8'd0;
            out_opt_reg    <= 8'd0;
            out_len_reg    <= 16'd0;
            out_fid_reg    <= 8'd0;
            out_dstat_reg  <= 8'd0;
            out_status_reg <= 3'd0;
            if (head.cmd.op == afrd_pkg::OP_PAYLOAD)
                out_data_reg <= head.cmd.data;
            else
            begin
                out_status_reg <= head.cmd.status;
                if (head.cmd.status == afrd_pkg::ST_RX_OK)
                begin
                    out_src_reg  <= src_reg;
                    out_rssi_reg <= rssi_reg;
                    out_opt_reg  <= opt_reg;
                    out_len_reg  <= head.cmd.len;
                end
                else if (head.cmd.status == afrd_pkg::ST_TX_OK)
                begin
                    out_fid_reg   <= fid_reg;
                    out_dstat_reg <= dstat_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (result_ch.ready)
            out_valid_reg <= 1'b0;
    end

    assign result_ch.valid           = out_valid_reg;
    assign result_ch.kind            = out_kind_reg;
    assign result_ch.data            = out_data_reg;
    assign result_ch.src_addr        = out_src_reg;
    assign result_ch.rssi            = out_rssi_reg;
    assign result_ch.rx_options      = out_opt_reg;
    assign result_ch.payload_len     = out_len_reg;
    assign result_ch.frame_id        = out_fid_reg;
    assign result_ch.delivery_status = out_dstat_reg;
    assign result_ch.status          = out_status_reg;
    assign result_ch.last            = out_kind_reg;

endmodule
`default_nettype wire

// File: rtl/api_frame_receive_deframer_core.sv
// Top level of the API frame receive deframer: parser, command queue, result stage.
// Throughput: one byte per cycle; the parser stalls only when the command queue is full.
// The parser writes its commands into the command queue; the result stage loads a result from
// the head of the queue into its output register once that register is free.
// Reset: parser hunts for a start byte, queue empty, no result pending.
`default_nettype none
module api_frame_receive_deframer_core #(
    parameter int QUEUE_DEPTH = afrd_pkg::QUEUE_DEPTH
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    afrd_byte_if.sink     byte_ch,
    afrd_result_if.source result_ch
);

    afrd_pkg::slot_t push;
    afrd_pkg::slot_t head;
    logic            queue_full;
    logic            pop;

    afrd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .queue_full (queue_full),
        .push       (push)
    );

    afrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .head  (head),
        .pop   (pop)
    );

    afrd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .result_ch (result_ch)
    );

endmodule
`default_nettype wire
